FILE: design/windowed_ratio_alert_qualifier_assert.svh
// Assertion macros for the windowed ratio alert qualifier.
// No dependencies; included by the top level inside its module body.
`ifndef WINDOWED_RATIO_ALERT_QUALIFIER_ASSERT_SVH
`define WINDOWED_RATIO_ALERT_QUALIFIER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define WRAQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define WRAQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/wraq_pkg.sv
// Shared types and constants for the windowed ratio alert qualifier.
// No dependencies.
`timescale 1ns / 1ps

package wraq_pkg;

   localparam int FIFO_DEPTH = 1024;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
   localparam int TIME_W     = 32;
   localparam int WIN_W      = 22;
   localparam int RATIO_W    = 16;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;

   localparam logic [1:0] REG_WINDOW = 2'd0;
   localparam logic [1:0] REG_RATIO  = 2'd1;
   localparam logic [1:0] REG_WAIT   = 2'd2;

   localparam logic [WIN_W-1:0]   WINDOW_RESET = WIN_W'(1000);
   localparam logic [RATIO_W-1:0] RATIO_RESET  = RATIO_W'(32768);
   localparam logic [WIN_W-1:0]   WAIT_RESET   = WIN_W'(1000);

   typedef struct packed {
      logic              detect;
      logic [TIME_W-1:0] timestamp_ms;
   } req_payload_type;

   typedef struct packed {
      logic              alert;
      logic [TIME_W-1:0] elapsed_ms;
      logic              overflow;
   } rsp_payload_type;

   typedef struct packed {
      logic              det;
      logic [TIME_W-1:0] stamp;
   } rec_type;

   typedef struct packed {
      logic [WIN_W-1:0]   window_ms;
      logic [RATIO_W-1:0] ratio_q16;
      logic [WIN_W-1:0]   wait_ms;
   } cfg_type;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] ptr);
      return (ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
   endfunction

endpackage

FILE: design/windowed_ratio_alert_qualifier.sv
// Top level of the windowed ratio alert qualifier: handshakes, record FIFO control,
// ratio test and run tracking. Depends on wraq_pkg, wraq_csr, wraq_rec_mem and
// windowed_ratio_alert_qualifier_assert.svh.
`timescale 1ns / 1ps
//
//  channel | ports                              | payload
//  --------+------------------------------------+-------------------------------------
//  request | req_valid, req_stall, req_data     | detect, timestamp_ms
//  result  | rsp_valid, rsp_stall, rsp_data     | alert, elapsed_ms, overflow
//  config  | csr_psel/penable/pwrite/paddr/...  | window_ms @0, ratio_q16 @4, wait_ms @8
//
//  One transaction per cycle sustained while rsp_stall is low; a result passes through
//  the input register, then the result register, before it is valid.
//  The head record is read from the store ahead of use, at the head pointer that
//  the current transaction leaves behind, so no read sits in the per-item path.
//  Reset is synchronous; the record store is not cleared (the fill count guards it).
//  A stalled result holds; req_stall rises only while a result waits and a second
//  transaction sits in the input register.

module windowed_ratio_alert_qualifier (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  wraq_pkg::req_payload_type       req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output wraq_pkg::rsp_payload_type       rsp_data,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [wraq_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [wraq_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [wraq_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import wraq_pkg::*;

   cfg_type cfg;

   // pipeline registers
   logic            in_vld_ff, in_vld_in;
   req_payload_type in_ff;
   logic            out_vld_ff, out_vld_in;
   rsp_payload_type out_ff, out_in;

   // FIFO and run state
   logic [PTR_W-1:0]  head_ff, head_in;
   logic [PTR_W-1:0]  tail_ff, tail_in;
   logic [CNT_W-1:0]  tcnt_ff, tcnt_in;
   logic [CNT_W-1:0]  fcnt_ff, fcnt_in;
   logic [TIME_W-1:0] start_ff, start_in;
   logic              active_ff, active_in;

   // per-item datapath
   logic                     out_free, proc, req_acc;
   logic [CNT_W-1:0]         occ, tot3;
   logic                     full, empty;
   rec_type                  rd0, rd1, head_rec, new_rec;
   logic                     det;
   logic [TIME_W-1:0]        now, span, el;
   logic [CNT_W-1:0]         tc1, fc1, tc2, fc2, tc3, fc3;
   logic [PTR_W-1:0]         head1;
   logic                     expire;
   logic [CNT_W+RATIO_W-1:0] lhs, rhs;
   logic                     ratio_hi, ratio_lo;

   wraq_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // handshake: output register frees when empty or taken this cycle
   assign out_free  = !out_vld_ff || !rsp_stall;
   assign proc      = in_vld_ff && out_free;
   assign req_stall = in_vld_ff && !out_free;
   assign req_acc   = req_valid && !req_stall;

   assign det     = in_ff.detect;
   assign now     = in_ff.timestamp_ms;
   assign new_rec = '{det: det, stamp: now};

   // record store; rd0 = record at head, rd1 = record after head
   wraq_rec_mem u_mem (
      .clock    (clock),
      .wr_en    (proc),
      .wr_addr  (tail_ff),
      .wr_data  (new_rec),
      .rd_addr0 (head_in),
      .rd_addr1 (ptr_next(head_in)),
      .rd_data0 (rd0),
      .rd_data1 (rd1)
   );

   assign occ   = tcnt_ff + fcnt_ff;
   assign full  = (occ >= CNT_W'(FIFO_DEPTH));
   assign empty = (occ == '0);

   always_comb begin
      // full store: oldest record goes first, its count taken back
      tc1   = tcnt_ff - CNT_W'(full && rd0.det);
      fc1   = fcnt_ff - CNT_W'(full && !rd0.det);
      head1 = full ? ptr_next(head_ff) : head_ff;
      tc2   = tc1 + CNT_W'(det);
      fc2   = fc1 + CNT_W'(!det);

      // oldest record after the append: the new one when the store was empty
      if (full) begin
         head_rec = rd1;
      end else if (empty) begin
         head_rec = new_rec;
      end else begin
         head_rec = rd0;
      end

      span   = now - head_rec.stamp;
      expire = (span > TIME_W'(cfg.window_ms));
      tc3    = tc2 - CNT_W'(expire && head_rec.det);
      fc3    = fc2 - CNT_W'(expire && !head_rec.det);
      tot3   = tc3 + fc3;

      // true/total against ratio_q16/65536 by cross-multiplication
      lhs      = {tc3, RATIO_W'(0)};
      rhs      = (CNT_W+RATIO_W)'(cfg.ratio_q16) * (CNT_W+RATIO_W)'(tot3);
      ratio_hi = (lhs > rhs);
      ratio_lo = (lhs < rhs);
      el       = now - start_ff;
   end

   always_comb begin
      head_in    = head_ff;
      tail_in    = tail_ff;
      tcnt_in    = tcnt_ff;
      fcnt_in    = fcnt_ff;
      start_in   = start_ff;
      active_in  = active_ff;
      out_in     = out_ff;
      in_vld_in  = req_acc ? 1'b1 : (proc ? 1'b0 : in_vld_ff);
      out_vld_in = proc ? 1'b1 : ((out_vld_ff && !rsp_stall) ? 1'b0 : out_vld_ff);

      if (proc) begin
         head_in            = expire ? ptr_next(head1) : head1;
         tail_in            = ptr_next(tail_ff);
         tcnt_in            = tc3;
         fcnt_in            = fc3;
         out_in.alert       = 1'b0;
         out_in.elapsed_ms  = '0;
         out_in.overflow    = full;

         if (expire) begin
            if (det) begin
               if (!active_ff) begin
                  start_in  = now;
                  active_in = 1'b1;
               end else if (ratio_hi) begin
                  // run holds; alert once it has lasted past wait_ms
                  if (el > TIME_W'(cfg.wait_ms)) begin
                     out_in.alert      = 1'b1;
                     out_in.elapsed_ms = el;
                  end
               end else begin
                  start_in = now;
               end
            end else if (active_ff && ratio_lo) begin
               active_in = 1'b0;
               start_in  = '0;
            end
         end else if (det && !active_ff) begin
            start_in  = now;
            active_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         head_ff    <= '0;
         tail_ff    <= '0;
         tcnt_ff    <= '0;
         fcnt_ff    <= '0;
         start_ff   <= '0;
         active_ff  <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
         head_ff    <= head_in;
         tail_ff    <= tail_in;
         tcnt_ff    <= tcnt_in;
         fcnt_ff    <= fcnt_in;
         start_ff   <= start_in;
         active_ff  <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         in_ff <= req_data;
      end
      out_ff <= out_in;
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

`include "windowed_ratio_alert_qualifier_assert.svh"

   `WRAQ_ASSERT_NOW(a_occ_bound, clock, reset, 1'b1, occ <= CNT_W'(FIFO_DEPTH), "record count exceeds store depth")
   `WRAQ_ASSERT_NOW(a_ptr_meet, clock, reset, empty || full, head_ff == tail_ff, "head and tail disagree with fill count")
   `WRAQ_ASSERT_NOW(a_no_alert_zero, clock, reset, rsp_valid && !rsp_data.alert, rsp_data.elapsed_ms == '0, "elapsed time without alert")
   `WRAQ_ASSERT_NEXT(a_alert_run, clock, reset, proc && out_in.alert, active_ff, "alert raised outside an active run")

endmodule

FILE: design/wraq_csr.sv
// Configuration registers behind the APB-style port.
// Depends on wraq_pkg.
`timescale 1ns / 1ps

module wraq_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [wraq_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [wraq_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [wraq_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready,
   output wraq_pkg::cfg_type               cfg
);
   import wraq_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic [1:0] reg_idx;
   logic       wr_en;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[3:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_WINDOW: cfg_in.window_ms = csr_pwdata[WIN_W-1:0];
            REG_RATIO:  cfg_in.ratio_q16 = csr_pwdata[RATIO_W-1:0];
            REG_WAIT:   cfg_in.wait_ms   = csr_pwdata[WIN_W-1:0];
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_WINDOW: csr_prdata = CSR_DATA_W'(cfg_ff.window_ms);
         REG_RATIO:  csr_prdata = CSR_DATA_W'(cfg_ff.ratio_q16);
         REG_WAIT:   csr_prdata = CSR_DATA_W'(cfg_ff.wait_ms);
         default:    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_ms <= WINDOW_RESET;
         cfg_ff.ratio_q16 <= RATIO_RESET;
         cfg_ff.wait_ms   <= WAIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: design/wraq_rec_mem.sv
// Record store: one write port, two registered read ports with write bypass.
// Depends on wraq_pkg.
`timescale 1ns / 1ps

module wraq_rec_mem (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [wraq_pkg::PTR_W-1:0] wr_addr,
   input  wraq_pkg::rec_type          wr_data,
   input  logic [wraq_pkg::PTR_W-1:0] rd_addr0,
   input  logic [wraq_pkg::PTR_W-1:0] rd_addr1,
   output wraq_pkg::rec_type          rd_data0,
   output wraq_pkg::rec_type          rd_data1
);
   import wraq_pkg::*;

   rec_type mem [FIFO_DEPTH];
   rec_type rd0_ff, rd1_ff, wr_data_ff;
   logic    byp0_ff, byp1_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd0_ff     <= mem[rd_addr0];
      rd1_ff     <= mem[rd_addr1];
      byp0_ff    <= wr_en && (rd_addr0 == wr_addr);
      byp1_ff    <= wr_en && (rd_addr1 == wr_addr);
      wr_data_ff <= wr_data;
   end

   // read-during-write returns the new record
   assign rd_data0 = byp0_ff ? wr_data_ff : rd0_ff;
   assign rd_data1 = byp1_ff ? wr_data_ff : rd1_ff;

endmodule
